>>> design/gtg_pkg.sv
// shared types, constants and the arctangent table for the go-to-goal controller
// no dependencies
package gtg_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int MAX_STAGES    = 24;
	localparam int NUM_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

	localparam int POSW = 16;
	localparam int HW   = 13;
	localparam int XW   = 27;
	localparam int ZW   = 24;
	localparam int IDXW = 5;

	localparam int TOLW   = 16;
	localparam int GAINW  = 12;
	localparam int DISTW  = 18;
	localparam int SPEEDW = 18;
	localparam int RATEW  = 16;

	localparam logic signed [ZW-1:0] HALF_PI_Q20  = 24'sd1647099;
	localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;

	typedef enum logic [2:0] {
		REG_GOAL_X       = 3'd0,
		REG_GOAL_Y       = 3'd1,
		REG_TOLERANCE    = 3'd2,
		REG_LINEAR_GAIN  = 3'd3,
		REG_ANGULAR_GAIN = 3'd4
	} gtg_reg_t;

	typedef struct packed {
		logic                 valid;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [HW-1:0] hd;
	} gtg_stage_t;

	function automatic logic signed [ZW-1:0] atan_q20(input logic [IDXW-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:    a = 24'sd823550;
			5'd1:    a = 24'sd486170;
			5'd2:    a = 24'sd256879;
			5'd3:    a = 24'sd130396;
			5'd4:    a = 24'sd65451;
			5'd5:    a = 24'sd32757;
			5'd6:    a = 24'sd16383;
			5'd7:    a = 24'sd8192;
			5'd8:    a = 24'sd4096;
			5'd9:    a = 24'sd2048;
			5'd10:   a = 24'sd1024;
			5'd11:   a = 24'sd512;
			5'd12:   a = 24'sd256;
			5'd13:   a = 24'sd128;
			5'd14:   a = 24'sd64;
			5'd15:   a = 24'sd32;
			5'd16:   a = 24'sd16;
			5'd17:   a = 24'sd8;
			5'd18:   a = 24'sd4;
			5'd19:   a = 24'sd2;
			5'd20:   a = 24'sd1;
			default: a = 24'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> design/go_to_goal_controller.sv
// go-to-goal proportional controller: config registers, quadrant pre-rotation,
// a chain of cordic cells and the output scaling stages
// depends on gtg_pkg, gtg_cordic_cell, gtg_post
// done is registered through chain[0], each cordic cell, then valid_s1, valid_s2, valid_s3 and done in gtg_post
// throughput: one item per cycle, busy stays low; set by the one-cell-per-iteration chain
// reset: config returns to goal 0, tolerance 10, gains 384 and 512; pipeline empties
module go_to_goal_controller
	import gtg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [POSW-1:0]   pose_x,
	input  logic signed [POSW-1:0]   pose_y,
	input  logic signed [HW-1:0]     pose_heading,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	output logic                     done,
	output logic [SPEEDW-1:0]        linear_speed,
	output logic signed [RATEW-1:0]  angular_rate,
	output logic                     arrived
);

	logic signed [POSW-1:0] goal_x_q, goal_y_q;
	logic [TOLW-1:0]        tol_q;
	logic [GAINW-1:0]       lin_gain_q, ang_gain_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			tol_q      <= 16'd10;
			lin_gain_q <= 12'd384;
			ang_gain_q <= 12'd512;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gtg_reg_t'(cfg_index))
				REG_GOAL_X:       goal_x_q   <= cfg_data;
				REG_GOAL_Y:       goal_y_q   <= cfg_data;
				REG_TOLERANCE:    tol_q      <= cfg_data;
				REG_LINEAR_GAIN:  lin_gain_q <= cfg_data[GAINW-1:0];
				REG_ANGULAR_GAIN: ang_gain_q <= cfg_data[GAINW-1:0];
				default: ;
			endcase
		end
	end

	// difference vector with guard bits, then rotate into the right half plane
	logic signed [16:0]   dx, dy;
	logic signed [XW-1:0] gx, gy, rx, ry;
	logic signed [ZW-1:0] rz;

	always_comb begin
		dx = 17'(goal_x_q) - 17'(pose_x);
		dy = 17'(goal_y_q) - 17'(pose_y);
		gx = XW'(dx) <<< 8;
		gy = XW'(dy) <<< 8;
		rx = gx;
		ry = gy;
		rz = '0;
		if (gx[XW-1]) begin
			if (!gy[XW-1]) begin
				rx = gy;
				ry = -gx;
				rz = HALF_PI_Q20;
			end else begin
				rx = -gy;
				ry = gx;
				rz = -HALF_PI_Q20;
			end
		end
	end

	gtg_stage_t chain [NUM_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0].valid <= start && !busy;
			chain[0].x     <= rx;
			chain[0].y     <= ry;
			chain[0].z     <= rz;
			chain[0].hd    <= pose_heading;
		end
	end

	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
		gtg_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.idx    (IDXW'(i)),
			.q      (chain[i+1])
		);
	end

	gtg_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.d        (chain[NUM_STAGES]),
		.tol      (tol_q),
		.lin_gain (lin_gain_q),
		.ang_gain (ang_gain_q),
		.done     (done),
		.speed    (linear_speed),
		.rate     (angular_rate),
		.arrived  (arrived)
	);

endmodule

>>> design/gtg_cordic_cell.sv
// one vectoring cordic iteration with its pipeline register
// depends on gtg_pkg
module gtg_cordic_cell
	import gtg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  gtg_stage_t        d,
	input  logic [IDXW-1:0]   idx,
	output gtg_stage_t        q
);

	logic signed [XW-1:0] x_in, y_in, xs, ys, nx, ny;
	logic signed [ZW-1:0] z_in, nz, ang;

	always_comb begin
		x_in = d.x;
		y_in = d.y;
		z_in = d.z;
		xs   = x_in >>> idx;
		ys   = y_in >>> idx;
		ang  = atan_q20(idx);
		if (!y_in[XW-1]) begin
			nx = x_in + ys;
			ny = y_in - xs;
			nz = z_in + ang;
		end else begin
			nx = x_in - ys;
			ny = y_in + xs;
			nz = z_in - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q.valid <= d.valid;
			q.x     <= nx;
			q.y     <= ny;
			q.z     <= nz;
			q.hd    <= d.hd;
		end
	end

endmodule

>>> design/gtg_post.sv
// distance and bearing scaling, arrival test, gains and saturation
// depends on gtg_pkg
module gtg_post
	import gtg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  gtg_stage_t               d,
	input  logic [TOLW-1:0]          tol,
	input  logic [GAINW-1:0]         lin_gain,
	input  logic [GAINW-1:0]         ang_gain,
	output logic                     done,
	output logic [SPEEDW-1:0]        speed,
	output logic signed [RATEW-1:0]  rate,
	output logic                     arrived
);

	// stage 1: distance product and rounded bearing
	logic                 valid_s1;
	logic [41:0]          prod_s1;
	logic signed [13:0]   bear_s1;
	logic signed [HW-1:0] hd_s1;
	logic [XW-2:0]        xpos;
	logic signed [ZW-1:0] zr;

	always_comb begin
		xpos = d.x[XW-1] ? '0 : d.x[XW-2:0];
		zr   = d.z + ZW'(512);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 42'(xpos) * 42'(INV_GAIN_Q16);
		bear_s1 <= zr[ZW-1:10];
		hd_s1   <= d.hd;
	end

	// stage 2: distance and heading error
	logic                 valid_s2;
	logic [DISTW-1:0]     dist_s2;
	logic signed [14:0]   err_s2;
	logic [42:0]          dsum;

	always_comb begin
		dsum = {1'b0, prod_s1} + 43'(1 << 23);
	end

	always_ff @(posedge clk) begin
		dist_s2 <= dsum[24 +: DISTW];
		err_s2  <= 15'(bear_s1) - 15'(hd_s1);
	end

	// stage 3: arrival test and gain products
	logic                 valid_s3;
	logic                 arr_s3;
	logic [29:0]          sprod_s3;
	logic signed [27:0]   rprod_s3;

	always_ff @(posedge clk) begin
		arr_s3   <= dist_s2 <= {2'b00, tol};
		sprod_s3 <= 30'(dist_s2) * 30'(lin_gain);
		rprod_s3 <= 28'(err_s2) * 28'(signed'({1'b0, ang_gain}));
	end

	// stage 4: rounding, saturation and output register
	logic [30:0]        ssum;
	logic [22:0]        sq;
	logic signed [28:0] rsum;
	logic signed [20:0] rq;
	logic [SPEEDW-1:0]  speed_d;
	logic signed [RATEW-1:0] rate_d;

	always_comb begin
		ssum = {1'b0, sprod_s3} + 31'd128;
		sq   = ssum[30:8];
		rsum = 29'(rprod_s3) + 29'sd128;
		rq   = rsum[28:8];
		if (sq > 23'(2**SPEEDW - 1)) begin
			speed_d = '1;
		end else begin
			speed_d = sq[SPEEDW-1:0];
		end
		if (rq > 21'sd32767) begin
			rate_d = 16'sd32767;
		end else if (rq < -21'sd32768) begin
			rate_d = -16'sd32768;
		end else begin
			rate_d = rq[RATEW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		speed   <= arr_s3 ? '0 : speed_d;
		rate    <= arr_s3 ? '0 : rate_d;
		arrived <= arr_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

endmodule

>>> verif/gtg_steer_checker.sv
`timescale 1ns / 100ps
// checker for the go-to-goal controller: tracks register writes and accepted poses, predicts
// each velocity command and compares it with the result port
// depends on gtg_pkg
module gtg_steer_checker
	import gtg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [POSW-1:0]   pose_x,
	input  logic signed [POSW-1:0]   pose_y,
	input  logic signed [HW-1:0]     pose_heading,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     done,
	input  logic [SPEEDW-1:0]        linear_speed,
	input  logic signed [RATEW-1:0]  angular_rate,
	input  logic                     arrived,
	output int                       fail_count,
	output int                       pending
);

	localparam longint SPEED_SAT = 262143;
	localparam longint RATE_HI   = 32767;
	localparam longint RATE_LO   = -32768;

	typedef struct {
		logic [SPEEDW-1:0]       speed;
		logic signed [RATEW-1:0] rate;
		logic                    arrived;
	} steer_cmd_t;

	longint atan_step_q20 [0:MAX_STAGES-1] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0, 0, 0
	};

	logic signed [POSW-1:0] goal_x;
	logic signed [POSW-1:0] goal_y;
	logic [TOLW-1:0]        tolerance;
	logic [GAINW-1:0]       lin_gain;
	logic [GAINW-1:0]       ang_gain;

	steer_cmd_t steer_pending [$];

	function automatic steer_cmd_t predict_steering(input logic signed [POSW-1:0] px,
			input logic signed [POSW-1:0] py, input logic signed [HW-1:0] hd);
		longint x, y, z, t, xs, ys, distance, bearing, speed, rate;
		steer_cmd_t c;
		x = (longint'(goal_x) - longint'(px)) * 256;
		y = (longint'(goal_y) - longint'(py)) * 256;
		z = 0;
		// quadrant pre-rotation into the right half plane
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(HALF_PI_Q20);
			end else begin
				x = -y;
				y = t;
				z = -longint'(HALF_PI_Q20);
			end
		end
		for (int i = 0; i < NUM_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_step_q20[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_step_q20[i];
			end
		end
		if (x < 0)
			x = 0;
		distance = (x * longint'(INV_GAIN_Q16) + (longint'(1) <<< 23)) >>> 24;
		bearing = (z + 512) >>> 10;
		if (distance <= longint'(tolerance)) begin
			c.speed = '0;
			c.rate = '0;
			c.arrived = 1'b1;
			return c;
		end
		speed = (distance * longint'(lin_gain) + 128) >>> 8;
		if (speed > SPEED_SAT)
			speed = SPEED_SAT;
		rate = ((bearing - longint'(hd)) * longint'(ang_gain) + 128) >>> 8;
		if (rate > RATE_HI)
			rate = RATE_HI;
		if (rate < RATE_LO)
			rate = RATE_LO;
		c.speed = speed[SPEEDW-1:0];
		c.rate = rate[RATEW-1:0];
		c.arrived = 1'b0;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		steer_cmd_t exp_cmd;
		if (!arst_n) begin
			goal_x <= '0;
			goal_y <= '0;
			tolerance <= 16'd10;
			lin_gain <= 12'd384;
			ang_gain <= 12'd512;
			steer_pending.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (steer_pending.size() == 0) begin
					$display("%0t: result with no item outstanding: speed %0d rate %0d arrived %0b",
						$time, linear_speed, angular_rate, arrived);
					fail_count++;
				end else begin
					exp_cmd = steer_pending.pop_front();
					if (linear_speed !== exp_cmd.speed || angular_rate !== exp_cmd.rate ||
							arrived !== exp_cmd.arrived) begin
						$display("%0t: expected speed %0d rate %0d arrived %0b, got %0d %0d %0b",
							$time, exp_cmd.speed, exp_cmd.rate, exp_cmd.arrived,
							linear_speed, angular_rate, arrived);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				steer_pending.push_back(predict_steering(pose_x, pose_y, pose_heading));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GOAL_X:       goal_x <= cfg_data;
					REG_GOAL_Y:       goal_y <= cfg_data;
					REG_TOLERANCE:    tolerance <= cfg_data;
					REG_LINEAR_GAIN:  lin_gain <= cfg_data[GAINW-1:0];
					REG_ANGULAR_GAIN: ang_gain <= cfg_data[GAINW-1:0];
					default: ;
				endcase
			end
			pending = steer_pending.size();
		end
	end

endmodule

>>> verif/go_to_goal_controller_test.sv
`timescale 1ns / 100ps
// testbench top for the go-to-goal controller: clock, reset, register writes and pose items
// depends on gtg_pkg, go_to_goal_controller and gtg_steer_checker
module go_to_goal_controller_test;
	import gtg_pkg::*;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int         NUM_PHASES   = 30;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [POSW-1:0]  pose_x;
	logic signed [POSW-1:0]  pose_y;
	logic signed [HW-1:0]    pose_heading;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [2:0]              cfg_index;
	logic [15:0]             cfg_data;
	logic                    done;
	logic [SPEEDW-1:0]       linear_speed;
	logic signed [RATEW-1:0] angular_rate;
	logic                    arrived;
	int                      fail_count;
	int                      pending;

	int cur_gx;
	int cur_gy;
	int cur_tol;

	go_to_goal_controller dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .linear_speed(linear_speed),
		.angular_rate(angular_rate), .arrived(arrived)
	);

	gtg_steer_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .linear_speed(linear_speed),
		.angular_rate(angular_rate), .arrived(arrived),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("go_to_goal_controller_test NOT OK");
		$finish;
	end

	task automatic send_pose(input logic signed [POSW-1:0] px, input logic signed [POSW-1:0] py,
			input logic signed [HW-1:0] hd, input int gap);
		@(negedge clk);
		start <= 1'b1;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= hd;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [POSW-1:0] clamp_pos(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[POSW-1:0];
	endfunction

	function automatic int pick_gap;
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	function automatic logic [15:0] pick_gain;
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'd4095;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(4095));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_config(input bit all_regs);
		logic [15:0] v;
		if (all_regs || $urandom_range(1)) begin
			case ($urandom_range(5))
				0: v = 16'h8000;
				1: v = 16'h7FFF;
				2: v = 16'($urandom_range(4000)) - 16'd2000;
				default: v = 16'($urandom);
			endcase
			write_register(REG_GOAL_X, v);
			cur_gx = int'($signed(v));
		end
		if (all_regs || $urandom_range(1)) begin
			case ($urandom_range(5))
				0: v = 16'h8000;
				1: v = 16'h7FFF;
				2: v = 16'($urandom_range(4000)) - 16'd2000;
				default: v = 16'($urandom);
			endcase
			write_register(REG_GOAL_Y, v);
			cur_gy = int'($signed(v));
		end
		if (all_regs || $urandom_range(1)) begin
			case ($urandom_range(4))
				0: v = 16'd0;
				1: v = 16'hFFFF;
				2: v = 16'($urandom_range(64));
				3: v = 16'($urandom_range(4096));
				default: v = 16'($urandom);
			endcase
			write_register(REG_TOLERANCE, v);
			cur_tol = int'(v);
		end
		if (all_regs || $urandom_range(1))
			write_register(REG_LINEAR_GAIN, pick_gain());
		if (all_regs || $urandom_range(1))
			write_register(REG_ANGULAR_GAIN, pick_gain());
		if ($urandom_range(3) == 0)
			write_register(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom));
	endtask

	task automatic random_pose(input int gap);
		logic signed [POSW-1:0] px, py;
		logic signed [HW-1:0]   hd;
		int                     k, span;
		k = $urandom_range(99);
		if (k < 55) begin
			px = 16'($urandom);
			py = 16'($urandom);
		end else if (k < 75) begin
			case ($urandom_range(2))
				0: span = 4;
				1: span = (cur_tol < 2000) ? cur_tol + 2 : 2000;
				default: span = 1024;
			endcase
			px = clamp_pos(cur_gx + int'($urandom_range(2 * span)) - span);
			py = clamp_pos(cur_gy + int'($urandom_range(2 * span)) - span);
		end else if (k < 88) begin
			// on an axis through the goal
			if ($urandom_range(1)) begin
				px = 16'($urandom);
				py = cur_gy[POSW-1:0];
			end else begin
				px = cur_gx[POSW-1:0];
				py = 16'($urandom);
			end
		end else begin
			case ($urandom_range(2))
				0: px = 16'h8000;
				1: px = 16'h7FFF;
				default: px = cur_gx[POSW-1:0];
			endcase
			case ($urandom_range(2))
				0: py = 16'h8000;
				1: py = 16'h7FFF;
				default: py = cur_gy[POSW-1:0];
			endcase
		end
		if ($urandom_range(4) != 0) begin
			hd = 13'($urandom_range(8191));
		end else begin
			case ($urandom_range(2))
				0: hd = -13'sd4096;
				1: hd = 13'sd4095;
				default: hd = '0;
			endcase
		end
		send_pose(px, py, hd, gap);
	endtask

	initial begin
		int n;
		bit steady;
		arst_n = 1'b0;
		start = 1'b0;
		pose_x = '0;
		pose_y = '0;
		pose_heading = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_gx = 0;
		cur_gy = 0;
		cur_tol = 10;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: goal at origin
		send_pose(0, 0, 0, 0);
		send_pose(5, -3, 100, 0);
		send_pose(11, 0, 0, 1);
		send_pose(1024, 0, 0, 0);
		send_pose(-1024, 0, -4096, 0);
		send_pose(0, 1024, 4095, 2);
		send_pose(0, -1024, 0, 0);
		send_pose(-32768, -32768, -4096, 0);
		send_pose(32767, 32767, 4095, 0);
		send_pose(32767, -32768, 0, 0);
		send_pose(-32768, 32767, -1, 0);
		drain();

		// far corner goal, full gains, zero tolerance
		write_register(REG_GOAL_X, 16'h7FFF);
		write_register(REG_GOAL_Y, 16'h8000);
		write_register(REG_LINEAR_GAIN, 16'hFFFF);
		write_register(REG_ANGULAR_GAIN, 16'd4095);
		write_register(REG_TOLERANCE, 16'd0);
		write_register(REG_SPARE_LO, 16'h1234);
		write_register(REG_SPARE_HI, 16'hFFFF);
		send_pose(-32768, 32767, 4095, 0);
		send_pose(-32768, 32767, -4096, 0);
		send_pose(32767, -32768, 0, 0);
		send_pose(32767, -32767, 0, 0);
		send_pose(32767, 0, 0, 0);
		drain();

		// zero gains, widest tolerance
		write_register(REG_TOLERANCE, 16'hFFFF);
		write_register(REG_LINEAR_GAIN, 16'd0);
		write_register(REG_ANGULAR_GAIN, 16'd0);
		write_register(REG_GOAL_X, 16'h8000);
		write_register(REG_GOAL_Y, 16'h7FFF);
		send_pose(32767, -32768, 0, 0);
		send_pose(0, 0, 1234, 0);
		send_pose(-32768, 32767, 0, 0);
		drain();
		cur_gx = -32768;
		cur_gy = 32767;
		cur_tol = 65535;

		for (int p = 0; p < NUM_PHASES; p++) begin
			random_config(p == 0);
			steady = (p % 4 == 1);
			n = $urandom_range(64, 40);
			for (int j = 0; j < n; j++)
				random_pose(steady ? 0 : pick_gap());
			drain();
		end

		repeat (NUM_STAGES + 12) @(negedge clk);
		if (fail_count == 0)
			$display("go_to_goal_controller_test OK");
		else
			$display("go_to_goal_controller_test NOT OK");
		$finish;
	end

endmodule
